// ===== rtl/sfb_pkg.sv =====
// shared types, constants and divide helpers for the servo feedback tracker
package sfb_pkg;

   // input word kinds
   localparam logic FUNC_FRAME = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // dense motor state codes
   localparam logic [3:0] STATUS_OFF     = 4'd0;
   localparam logic [3:0] STATUS_ON      = 4'd1;
   localparam logic [3:0] STATUS_UNKNOWN = 4'd8;
   localparam logic [3:0] NIB_FAULT_LO   = 4'd8;
   localparam logic [3:0] NIB_FAULT_HI   = 4'd13;
   localparam logic [3:0] NIB_FAULT_OFS  = 4'd6;

   // register map
   typedef enum logic [2:0] {
      CSR_POS_MIN       = 3'd0,
      CSR_POS_MAX       = 3'd1,
      CSR_VEL_MIN       = 3'd2,
      CSR_VEL_MAX       = 3'd3,
      CSR_TRQ_MIN       = 3'd4,
      CSR_TRQ_MAX       = 3'd5,
      CSR_DIRECTION     = 3'd6,
      CSR_OFFLINE_LIMIT = 3'd7
   } csr_index_type;

   localparam logic signed [23:0] POS_MIN_RST = -24'sd819200;
   localparam logic signed [23:0] POS_MAX_RST = 24'sd819200;
   localparam logic signed [23:0] VEL_MIN_RST = -24'sd2949120;
   localparam logic signed [23:0] VEL_MAX_RST = 24'sd2949120;
   localparam logic signed [23:0] TRQ_MIN_RST = -24'sd1179648;
   localparam logic signed [23:0] TRQ_MAX_RST = 24'sd1179648;
   localparam logic [15:0]        LIMIT_RST   = 16'd100;

   localparam logic [11:0] SPEED_ZERO_CODE = 12'd2047;

   // pi and two pi in q8.16
   localparam logic signed [25:0] PI_Q     = 26'sd205887;
   localparam logic signed [25:0] TWO_PI_Q = 26'sd411775;

   localparam logic signed [47:0] TOTAL_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] TOTAL_MIN = {1'b1, {47{1'b0}}};

   // status nibble to dense state
   function automatic logic [3:0] map_status(input logic [3:0] nib);
      logic [3:0] st;
      case (nib)
         4'd0:    st = STATUS_OFF;
         4'd1:    st = STATUS_ON;
         default: begin
            if (nib >= NIB_FAULT_LO && nib <= NIB_FAULT_HI) begin
               st = nib - NIB_FAULT_OFS;
            end else begin
               st = STATUS_UNKNOWN;
            end
         end
      endcase
      return st;
   endfunction

   // floor(m / 65535) by folding the high part back onto the low part
   function automatic logic signed [25:0] div_65535(input logic signed [41:0] m);
      logic signed [25:0] a1;
      logic signed [26:0] r1;
      logic signed [10:0] a2;
      logic signed [17:0] r2;
      logic signed [1:0]  a3;
      logic signed [17:0] r3;
      logic signed [1:0]  c;
      a1 = m[41:16];
      r1 = 27'(a1) + $signed({11'b0, m[15:0]});
      a2 = r1[26:16];
      r2 = 18'(a2) + $signed({2'b0, r1[15:0]});
      a3 = r2[17:16];
      r3 = 18'(a3) + $signed({2'b0, r2[15:0]});
      c  = 2'sd0;
      if (r3 < 18'sd0) begin
         c = -2'sd1;
      end else if (r3 >= 18'sd65535) begin
         c = 2'sd1;
      end
      return a1 + 26'(a2) + 26'(a3) + 26'(c);
   endfunction

   // floor(m / 4095), same folding on 12-bit digits
   function automatic logic signed [25:0] div_4095(input logic signed [37:0] m);
      logic signed [25:0] a1;
      logic signed [26:0] r1;
      logic signed [14:0] a2;
      logic signed [16:0] r2;
      logic signed [4:0]  a3;
      logic signed [13:0] r3;
      logic signed [1:0]  c;
      a1 = m[37:12];
      r1 = 27'(a1) + $signed({15'b0, m[11:0]});
      a2 = r1[26:12];
      r2 = 17'(a2) + $signed({5'b0, r1[11:0]});
      a3 = r2[16:12];
      r3 = 14'(a3) + $signed({2'b0, r2[11:0]});
      c  = 2'sd0;
      if (r3 < 14'sd0) begin
         c = -2'sd1;
      end else if (r3 >= 14'sd4095) begin
         c = 2'sd1;
      end
      return a1 + 26'(a2) + 26'(a3) + 26'(c);
   endfunction

endpackage

// ===== rtl/sfb_scaler.sv =====
// three-stage linear scaler for the angle, speed and torque codes
module sfb_scaler
   import sfb_pkg::*;
(
   input  logic               clock,
   input  logic               adv,
   input  logic [15:0]        acode,
   input  logic [11:0]        scode,
   input  logic [11:0]        tcode,
   input  logic signed [23:0] pos_min,
   input  logic signed [23:0] pos_max,
   input  logic signed [23:0] vel_min,
   input  logic signed [23:0] vel_max,
   input  logic signed [23:0] trq_min,
   input  logic signed [23:0] trq_max,
   output logic signed [23:0] angle,
   output logic signed [23:0] speed,
   output logic signed [23:0] torque
);

   logic signed [24:0] span_pos;
   logic signed [24:0] span_vel;
   logic signed [24:0] span_trq;

   logic signed [41:0] m_pos_ff, m_pos_in;
   logic signed [37:0] m_vel_ff, m_vel_in;
   logic signed [37:0] m_trq_ff, m_trq_in;
   logic               zero_b_ff;

   logic signed [25:0] q_pos_ff;
   logic signed [25:0] q_vel_ff;
   logic signed [25:0] q_trq_ff;
   logic               zero_c_ff;

   logic signed [25:0] sum_pos;
   logic signed [25:0] sum_vel;
   logic signed [25:0] sum_trq;

   logic signed [23:0] angle_ff;
   logic signed [23:0] speed_ff;
   logic signed [23:0] torque_ff;

   assign span_pos = 25'(pos_max) - 25'(pos_min);
   assign span_vel = 25'(vel_max) - 25'(vel_min);
   assign span_trq = 25'(trq_max) - 25'(trq_min);

   // code * span plus half the divisor, rounded down later
   assign m_pos_in = $signed({1'b0, acode}) * span_pos + 42'sd32767;
   assign m_vel_in = $signed({1'b0, scode}) * span_vel + 38'sd2047;
   assign m_trq_in = $signed({1'b0, tcode}) * span_trq + 38'sd2047;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_pos_ff  <= m_pos_in;
         m_vel_ff  <= m_vel_in;
         m_trq_ff  <= m_trq_in;
         zero_b_ff <= (scode == SPEED_ZERO_CODE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_pos_ff  <= div_65535(m_pos_ff);
         q_vel_ff  <= div_4095(m_vel_ff);
         q_trq_ff  <= div_4095(m_trq_ff);
         zero_c_ff <= zero_b_ff;
      end
   end

   assign sum_pos = 26'(pos_min) + q_pos_ff;
   assign sum_vel = 26'(vel_min) + q_vel_ff;
   assign sum_trq = 26'(trq_min) + q_trq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff  <= sum_pos[23:0];
         speed_ff  <= zero_c_ff ? 24'sd0 : sum_vel[23:0];
         torque_ff <= sum_trq[23:0];
      end
   end

   assign angle  = angle_ff;
   assign speed  = speed_ff;
   assign torque = torque_ff;

endmodule

// ===== rtl/servo_feedback_tracker.sv =====
// top level: motor feedback decode, multi-turn angle and online watchdog
//
//  port group   dir  handshake              contents
//  req_*        in   req_valid/req_ready    func, six feedback bytes
//  rsp_*        out  rsp_valid/rsp_ready    angle, speed, torque, total, status
//  csr_*        in   csr_wr_en              register index and write data
//
//  one word enters per cycle while the pipe advances; results pass through
//  the input register, multiply, divide fold, offset add and state update
//  the result register is the tracker state itself, so rsp_* only move when
//  the whole pipe advances, and the pipe advances when the output is empty
//  or taken; req_ready follows that same advance
//  synchronous active high reset restores the register defaults and state
module servo_feedback_tracker
   import sfb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [47:0]        req_frame_bytes,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_angle,
   output logic signed [23:0] rsp_speed,
   output logic signed [23:0] rsp_torque_fb,
   output logic signed [47:0] rsp_angle_total,
   output logic [3:0]         rsp_motor_status,
   output logic [3:0]         rsp_last_fault,
   output logic               rsp_online,
   // configuration
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   // configuration registers
   logic signed [23:0] pos_min_ff;
   logic signed [23:0] pos_max_ff;
   logic signed [23:0] vel_min_ff;
   logic signed [23:0] vel_max_ff;
   logic signed [23:0] trq_min_ff;
   logic signed [23:0] trq_max_ff;
   logic               direction_ff;
   logic [15:0]        limit_ff;

   // pipe control
   logic        adv;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        func1_ff, func2_ff, func3_ff, func4_ff;
   logic [47:0] frame1_ff;
   logic [3:0]  st2_ff, st3_ff, st4_ff;

   // scaled values arriving alongside stage 4
   logic signed [23:0] angle4;
   logic signed [23:0] speed4;
   logic signed [23:0] torque4;

   // tracker state, doubles as the result register
   logic               rsp_valid_ff;
   logic signed [23:0] prev_angle_ff;
   logic signed [23:0] cur_angle_ff;
   logic signed [23:0] cur_speed_ff;
   logic signed [23:0] cur_torque_ff;
   logic signed [47:0] total_ff, total_in;
   logic [15:0]        timeout_ff;
   logic               online_ff;
   logic [3:0]         status_ff;
   logic [3:0]         fault_ff;

   // angle step and tick arithmetic
   logic signed [24:0] diff;
   logic signed [25:0] step_raw;
   logic signed [25:0] step_wrap;
   logic signed [25:0] step;
   logic signed [48:0] total_sum;
   logic [16:0]        tick_next;

   // whole pipe moves when the output is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_min_ff   <= POS_MIN_RST;
         pos_max_ff   <= POS_MAX_RST;
         vel_min_ff   <= VEL_MIN_RST;
         vel_max_ff   <= VEL_MAX_RST;
         trq_min_ff   <= TRQ_MIN_RST;
         trq_max_ff   <= TRQ_MAX_RST;
         direction_ff <= 1'b0;
         limit_ff     <= LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POS_MIN:       pos_min_ff   <= csr_wdata;
            CSR_POS_MAX:       pos_max_ff   <= csr_wdata;
            CSR_VEL_MIN:       vel_min_ff   <= csr_wdata;
            CSR_VEL_MAX:       vel_max_ff   <= csr_wdata;
            CSR_TRQ_MIN:       trq_min_ff   <= csr_wdata;
            CSR_TRQ_MAX:       trq_max_ff   <= csr_wdata;
            CSR_DIRECTION:     direction_ff <= csr_wdata[0];
            CSR_OFFLINE_LIMIT: limit_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // valid bits of the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload side of the pipe; status is mapped on its way out of stage 1
   always_ff @(posedge clock) begin
      if (adv) begin
         func1_ff  <= req_func;
         frame1_ff <= req_frame_bytes;
         func2_ff  <= func1_ff;
         st2_ff    <= map_status(frame1_ff[47:44]);
         func3_ff  <= func2_ff;
         st3_ff    <= st2_ff;
         func4_ff  <= func3_ff;
         st4_ff    <= st3_ff;
      end
   end

   sfb_scaler u_scaler (
      .clock   (clock),
      .adv     (adv),
      .acode   (frame1_ff[39:24]),
      .scode   (frame1_ff[23:12]),
      .tcode   (frame1_ff[11:0]),
      .pos_min (pos_min_ff),
      .pos_max (pos_max_ff),
      .vel_min (vel_min_ff),
      .vel_max (vel_max_ff),
      .trq_min (trq_min_ff),
      .trq_max (trq_max_ff),
      .angle   (angle4),
      .speed   (speed4),
      .torque  (torque4)
   );

   // angle step: nothing is added until a first nonzero reference exists
   assign diff     = 25'(angle4) - 25'(prev_angle_ff);
   assign step_raw = (prev_angle_ff == 24'sd0 && total_ff == 48'sd0) ? 26'sd0 : 26'(diff);

   // fold the step back into one half turn either way
   always_comb begin
      if (step_raw > PI_Q) begin
         step_wrap = step_raw - TWO_PI_Q;
      end else if (step_raw < -PI_Q) begin
         step_wrap = step_raw + TWO_PI_Q;
      end else begin
         step_wrap = step_raw;
      end
   end

   assign step      = direction_ff ? -step_wrap : step_wrap;
   assign total_sum = 49'(total_ff) + 49'(step);

   // saturate at the 48-bit limits
   always_comb begin
      if (total_sum[48] != total_sum[47]) begin
         total_in = total_sum[48] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
         total_in = total_sum[47:0];
      end
   end

   // watchdog count without wrap
   assign tick_next = {1'b0, timeout_ff} + 17'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         prev_angle_ff <= 24'sd0;
         cur_angle_ff  <= 24'sd0;
         cur_speed_ff  <= 24'sd0;
         cur_torque_ff <= 24'sd0;
         total_ff      <= 48'sd0;
         timeout_ff    <= LIMIT_RST;
         online_ff     <= 1'b0;
         status_ff     <= STATUS_OFF;
         fault_ff      <= STATUS_OFF;
      end else if (adv) begin
         rsp_valid_ff <= v4_ff;
         if (v4_ff) begin
            if (func4_ff == FUNC_FRAME) begin
               status_ff <= st4_ff;
               // every state other than off or on is latched, unknown included
               if (st4_ff != STATUS_OFF && st4_ff != STATUS_ON) begin
                  fault_ff <= st4_ff;
               end
               cur_angle_ff  <= angle4;
               cur_speed_ff  <= speed4;
               cur_torque_ff <= torque4;
               prev_angle_ff <= angle4;
               total_ff      <= total_in;
               timeout_ff    <= 16'd0;
               online_ff     <= 1'b1;
            end else begin
               if (tick_next > {1'b0, limit_ff}) begin
                  timeout_ff <= limit_ff;
                  online_ff  <= 1'b0;
                  status_ff  <= STATUS_OFF;
               end else begin
                  timeout_ff <= tick_next[15:0];
                  online_ff  <= 1'b1;
               end
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_angle        = cur_angle_ff;
   assign rsp_speed        = cur_speed_ff;
   assign rsp_torque_fb    = cur_torque_ff;
   assign rsp_angle_total  = total_ff;
   assign rsp_motor_status = status_ff;
   assign rsp_last_fault   = fault_ff;
   assign rsp_online       = online_ff;

endmodule

// ===== verif/servo_feedback_tracker_tb.sv =====
// testbench for servo_feedback_tracker: random feedback frames and ticks checked against a predictor
`timescale 1ns / 100ps

module servo_feedback_tracker_tb
   import sfb_pkg::*;
;

   localparam int RESET_CYCLES = 7;
   localparam int PIPE_LATENCY = 5;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_WORDS  = 216;

   // wrap and saturation bounds widened to the predictor's arithmetic
   localparam longint HALF_TURN   = PI_Q;
   localparam longint FULL_TURN   = TWO_PI_Q;
   localparam longint TOTAL_CEIL  = TOTAL_MAX;
   localparam longint TOTAL_FLOOR = TOTAL_MIN;

   // one input word as queued for the driver
   typedef struct {
      logic        func;
      logic [47:0] frame_bytes;
   } feedback_req_type;

   // one result word as the block should present it
   typedef struct packed {
      logic signed [23:0] angle;
      logic signed [23:0] speed;
      logic signed [23:0] torque_fb;
      logic signed [47:0] angle_total;
      logic [3:0]         motor_status;
      logic [3:0]         last_fault;
      logic               online;
   } feedback_word_type;

   // clock, reset and dut inputs, all known from time zero
   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic               req_func        = FUNC_FRAME;
   logic [47:0]        req_frame_bytes = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic signed [23:0] rsp_angle;
   logic signed [23:0] rsp_speed;
   logic signed [23:0] rsp_torque_fb;
   logic signed [47:0] rsp_angle_total;
   logic [3:0]         rsp_motor_status;
   logic [3:0]         rsp_last_fault;
   logic               rsp_online;
   logic               csr_wr_en       = 1'b0;
   logic [2:0]         csr_index       = '0;
   logic [23:0]        csr_wdata       = '0;

   // register copy, starts at the reset defaults
   logic signed [23:0] cfg_pos_min       = POS_MIN_RST;
   logic signed [23:0] cfg_pos_max       = POS_MAX_RST;
   logic signed [23:0] cfg_vel_min       = VEL_MIN_RST;
   logic signed [23:0] cfg_vel_max       = VEL_MAX_RST;
   logic signed [23:0] cfg_trq_min       = TRQ_MIN_RST;
   logic signed [23:0] cfg_trq_max       = TRQ_MAX_RST;
   logic               cfg_direction     = 1'b0;
   logic [15:0]        cfg_offline_limit = LIMIT_RST;

   // tracker state as the predictor sees it
   logic signed [23:0] trk_prev_angle = '0;
   logic signed [23:0] trk_angle      = '0;
   logic signed [23:0] trk_speed      = '0;
   logic signed [23:0] trk_torque     = '0;
   longint             trk_total      = 0;
   int unsigned        trk_timeout    = LIMIT_RST;
   logic               trk_online     = 1'b0;
   logic [3:0]         trk_status     = STATUS_OFF;
   logic [3:0]         trk_fault      = STATUS_OFF;

   // words waiting for the driver, and results waiting for the dut
   feedback_req_type  pending_words[$];
   feedback_word_type expected_feedback[$];
   feedback_req_type  next_word;
   feedback_word_type want;

   // bookkeeping
   int error_count     = 0;
   int words_in        = 0;
   int words_out       = 0;
   int frames_seen     = 0;
   int ticks_seen      = 0;
   int faults_latched  = 0;
   int offline_drops   = 0;
   int wraps_seen      = 0;
   int midpoints_seen  = 0;
   int settings_used   = 1;
   int burst_left      = 0;
   int gap_left        = 0;
   int stall_phase     = 0;
   int stall_mode      = 0;
   int hold_left       = 0;
   int holds_taken     = 0;
   int quiet_cycles    = 0;

   servo_feedback_tracker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_frame_bytes  (req_frame_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_angle        (rsp_angle),
      .rsp_speed        (rsp_speed),
      .rsp_torque_fb    (rsp_torque_fb),
      .rsp_angle_total  (rsp_angle_total),
      .rsp_motor_status (rsp_motor_status),
      .rsp_last_fault   (rsp_last_fault),
      .rsp_online       (rsp_online),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // status nibble to dense motor state
   function automatic logic [3:0] decode_state(input logic [3:0] nib);
      if (nib == STATUS_OFF) return STATUS_OFF;
      if (nib == STATUS_ON) return STATUS_ON;
      if (nib >= NIB_FAULT_LO && nib <= NIB_FAULT_HI) return nib - NIB_FAULT_OFS;
      return STATUS_UNKNOWN;
   endfunction

   // lo + code * (hi - lo) / full, nearest with halves rounded up
   function automatic logic signed [23:0] scale_to_range(input longint code, input longint lo,
                                                         input longint hi, input longint full);
      longint num;
      longint den;
      longint quo;
      num = 2 * code * (hi - lo) + full;
      den = 2 * full;
      quo = num / den;
      // truncating divide, pull negative remainders down to a floor
      if ((num % den) != 0 && num < 0) quo = quo - 1;
      return 24'(lo + quo);
   endfunction

   // apply one accepted word to the tracker state, return the result it yields
   function automatic feedback_word_type advance_tracker(input logic func,
                                                         input logic [47:0] bytes);
      logic [11:0]       scode;
      longint            step;
      longint            sum;
      int unsigned       next_count;
      feedback_word_type word;
      if (func == FUNC_FRAME) begin
         frames_seen++;
         trk_status = decode_state(bytes[47:44]);
         if (trk_status != STATUS_OFF && trk_status != STATUS_ON) begin
            trk_fault = trk_status;
            faults_latched++;
         end
         trk_angle = scale_to_range(bytes[39:24], cfg_pos_min, cfg_pos_max, 65535);
         scode = bytes[23:12];
         // midpoint speed code reads as standstill whatever the range
         if (scode == SPEED_ZERO_CODE) begin
            trk_speed = '0;
            midpoints_seen++;
         end else begin
            trk_speed = scale_to_range(scode, cfg_vel_min, cfg_vel_max, 4095);
         end
         trk_torque = scale_to_range(bytes[11:0], cfg_trq_min, cfg_trq_max, 4095);
         // no step until something has been accumulated
         step = 0;
         if (trk_prev_angle != 0 || trk_total != 0)
            step = longint'(trk_angle) - longint'(trk_prev_angle);
         if (step > HALF_TURN) begin
            step = step - FULL_TURN;
            wraps_seen++;
         end else if (step < -HALF_TURN) begin
            step = step + FULL_TURN;
            wraps_seen++;
         end
         if (cfg_direction) step = -step;
         sum = trk_total + step;
         if (sum > TOTAL_CEIL) sum = TOTAL_CEIL;
         if (sum < TOTAL_FLOOR) sum = TOTAL_FLOOR;
         trk_total      = sum;
         trk_prev_angle = trk_angle;
         trk_timeout    = 0;
         trk_online     = 1'b1;
      end else begin
         ticks_seen++;
         next_count = trk_timeout + 1;
         if (next_count > cfg_offline_limit) begin
            if (trk_online) offline_drops++;
            trk_timeout = cfg_offline_limit;
            trk_online  = 1'b0;
            trk_status  = STATUS_OFF;
         end else begin
            trk_timeout = next_count;
            trk_online  = 1'b1;
         end
      end
      word.angle        = trk_angle;
      word.speed        = trk_speed;
      word.torque_fb    = trk_torque;
      word.angle_total  = 48'(trk_total);
      word.motor_status = trk_status;
      word.last_fault   = trk_fault;
      word.online       = trk_online;
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // spare nibble of byte 0 gets random bits, it is not decoded
   task automatic push_frame(input logic [3:0] nib, input logic [15:0] acode,
                             input logic [11:0] scode, input logic [11:0] tcode);
      feedback_req_type w;
      w.func        = FUNC_FRAME;
      w.frame_bytes = {nib, 4'($urandom), acode, scode, tcode};
      pending_words.push_back(w);
   endtask

   // tick payload is ignored, fill it with noise anyway
   task automatic push_tick();
      feedback_req_type w;
      w.func        = FUNC_TICK;
      w.frame_bytes = {16'($urandom), 32'($urandom)};
      pending_words.push_back(w);
   endtask

   // 12-bit code biased toward the ends and the speed midpoint
   function automatic logic [11:0] pick_code12();
      case ($urandom_range(0, 15))
         0, 1:    return 12'd0;
         2, 3:    return 12'hFFF;
         4, 5:    return SPEED_ZERO_CODE;
         6:       return SPEED_ZERO_CODE - 12'd1;
         7:       return SPEED_ZERO_CODE + 12'd1;
         default: return 12'($urandom);
      endcase
   endfunction

   // mostly healthy motors, the rest any nibble at all
   function automatic logic [3:0] pick_nibble();
      case ($urandom_range(0, 3))
         0:       return STATUS_OFF;
         1:       return STATUS_ON;
         default: return 4'($urandom);
      endcase
   endfunction

   // frame runs with a drifting angle, tick runs up to tick_run, some noise
   task automatic queue_traffic(input int count, input int tick_run);
      int          queued;
      int          run;
      logic [15:0] acode;
      queued = 0;
      acode  = 16'($urandom);
      while (queued < count) begin
         case ($urandom_range(0, 9))
            0: begin
               // noise: a frame with nothing in common with its neighbors
               push_frame(4'($urandom), 16'($urandom), 12'($urandom), 12'($urandom));
               queued++;
            end
            1: begin
               run = $urandom_range(0, tick_run);
               repeat (run) push_tick();
               queued += run;
            end
            default: begin
               run = $urandom_range(1, 12);
               repeat (run) begin
                  // small moves cross the code wrap now and then, rarely a jump
                  if ($urandom_range(0, 15) == 0)
                     acode = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                  else
                     acode = acode + 16'($urandom_range(0, 8191)) - 16'd4096;
                  push_frame(pick_nibble(), acode, pick_code12(), pick_code12());
               end
               queued += run;
            end
         endcase
      end
   endtask

   // one register write per edge, enable stays up between back to back writes
   task automatic write_reg(input csr_index_type idx, input logic [23:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_POS_MIN:       cfg_pos_min       = data;
         CSR_POS_MAX:       cfg_pos_max       = data;
         CSR_VEL_MIN:       cfg_vel_min       = data;
         CSR_VEL_MAX:       cfg_vel_max       = data;
         CSR_TRQ_MIN:       cfg_trq_min       = data;
         CSR_TRQ_MAX:       cfg_trq_max       = data;
         CSR_DIRECTION:     cfg_direction     = data[0];
         CSR_OFFLINE_LIMIT: cfg_offline_limit = data[15:0];
         default: ;
      endcase
   endtask

   // full register set; unused upper data bits carry junk
   task automatic apply_settings(input logic [23:0] pmin, input logic [23:0] pmax,
                                 input logic [23:0] vmin, input logic [23:0] vmax,
                                 input logic [23:0] tmin, input logic [23:0] tmax,
                                 input logic dir, input logic [15:0] limit);
      write_reg(CSR_POS_MIN, pmin);
      write_reg(CSR_POS_MAX, pmax);
      write_reg(CSR_VEL_MIN, vmin);
      write_reg(CSR_VEL_MAX, vmax);
      write_reg(CSR_TRQ_MIN, tmin);
      write_reg(CSR_TRQ_MAX, tmax);
      write_reg(CSR_DIRECTION, {23'($urandom), dir});
      write_reg(CSR_OFFLINE_LIMIT, {8'($urandom), limit});
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // wait until every queued word went in and every result came out
   task automatic settle();
      while (pending_words.size() != 0 || req_valid || expected_feedback.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of words from the pending queue with random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // word taken at this edge, predict its result now
         if (req_valid && req_ready) begin
            expected_feedback.push_back(advance_tracker(req_func, req_frame_bytes));
            words_in++;
         end
         // offer a new word only once the last one is gone
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_valid       <= 1'b1;
               req_func        <= next_word.func;
               req_frame_bytes <= next_word.frame_bytes;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; a third of them follow without any gap
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: field by field check, stall pattern and long hold-offs
   // ---------------------------------------------------------------------
   task automatic compare_field(input string field, input logic signed [47:0] exp_val,
                                input logic signed [47:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s expected %0d got %0d", field, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         words_out++;
         if (expected_feedback.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            want = expected_feedback.pop_front();
            compare_field("angle", want.angle, rsp_angle);
            compare_field("speed", want.speed, rsp_speed);
            compare_field("torque_fb", want.torque_fb, rsp_torque_fb);
            compare_field("angle_total", want.angle_total, rsp_angle_total);
            compare_field("motor_status", want.motor_status, rsp_motor_status);
            compare_field("last_fault", want.last_fault, rsp_last_fault);
            compare_field("online", want.online, rsp_online);
         end
      end

      // stall style is picked anew each time the phase counter wraps
      stall_phase++;
      if (stall_phase >= 48) begin
         stall_phase = 0;
         stall_mode  = $urandom_range(0, 3);
      end

      // twice in the run: block the output while the sender keeps pushing
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_taken < 2 && words_out >= (holds_taken + 1) * 400 &&
                   pending_words.size() > 0) begin
         hold_left = HOLD_CYCLES;
         holds_taken++;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_phase % 3 == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without any word moving on either side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[servo_feedback_tracker] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed words on the reset settings
      push_tick();                                  // timeout already at limit: offline
      push_frame(STATUS_OFF, 16'h0000, 12'd0, 12'd0); // first frame adds no step
      push_frame(STATUS_ON, 16'hFFFF, 12'hFFF, 12'hFFF); // full-scale jump wraps
      push_frame(STATUS_ON, 16'h8000, SPEED_ZERO_CODE, 12'd2048);
      for (int nib = NIB_FAULT_LO; nib <= NIB_FAULT_HI; nib++)
         push_frame(4'(nib), 16'($urandom), 12'($urandom), 12'($urandom));
      for (int nib = STATUS_ON + 1; nib < NIB_FAULT_LO; nib++)
         push_frame(4'(nib), 16'($urandom), 12'($urandom), 12'($urandom));
      push_frame(4'hE, 16'h7F00, 12'd1, 12'hFFE);
      push_frame(4'hF, 16'h7E00, 12'hFFE, 12'd1);
      push_frame(STATUS_ON, 16'h7D00, 12'd100, 12'd3000); // fault stays latched
      repeat (3) push_tick();
      settle();

      // widest angle range, reversed speed range, flat torque, inverted sense,
      // every tick drops offline
      apply_settings(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                     24'h800000, 24'h800000, 1'b1, 16'd0);
      queue_traffic(PHASE_WORDS, 3);
      settle();

      // reversed angle range, widest speed range, widest limit
      apply_settings(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
                     24'h7FFFFF, 24'h800000, 1'b0, 16'hFFFF);
      queue_traffic(PHASE_WORDS, 8);
      settle();

      // random ranges with a short watchdog limit
      begin
         int lim;
         lim = $urandom_range(1, 12);
         apply_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                        24'($urandom), 24'($urandom), 1'($urandom), 16'(lim));
         queue_traffic(PHASE_WORDS, lim + 3);
         settle();
      end

      // stock ranges, inverted sense, tick runs long enough to go offline
      apply_settings(POS_MIN_RST, POS_MAX_RST, VEL_MIN_RST, VEL_MAX_RST,
                     TRQ_MIN_RST, TRQ_MAX_RST, 1'b1, LIMIT_RST);
      queue_traffic(PHASE_WORDS, LIMIT_RST + 4);
      settle();

      // random again, limit anywhere in the low range including zero
      begin
         int lim;
         lim = $urandom_range(0, 40);
         apply_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                        24'($urandom), 24'($urandom), 1'($urandom), 16'(lim));
         queue_traffic(PHASE_WORDS, lim + 3);
         settle();
      end

      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (expected_feedback.size() != 0) begin
         $error("%0d result words never arrived", expected_feedback.size());
         error_count++;
      end

      $display("run covered %0d frames and %0d ticks under %0d register settings, %0d checked",
               frames_seen, ticks_seen, settings_used, words_out);
      $display("with %0d fault latches, %0d offline drops, %0d wrapped steps, %0d speed midpoints",
               faults_latched, offline_drops, wraps_seen, midpoints_seen);
      if (error_count == 0) begin
         $display("[servo_feedback_tracker] OK");
      end else begin
         $display("[servo_feedback_tracker] ERROR");
      end
      $finish;
   end

endmodule
